// File: hdl/key_debounce_event_generator_macros.svh
// Assertion macros for the key debounce event generator
`ifndef KEY_DEBOUNCE_EVENT_GENERATOR_MACROS_SVH
`define KEY_DEBOUNCE_EVENT_GENERATOR_MACROS_SVH
`ifndef SYNTHESIS
`define KDEG_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define KDEG_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define KDEG_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define KDEG_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: hdl/kdeg_pkg.sv
// Types and codes shared by the key debounce event generator
`timescale 1ns / 1ps
package kdeg_pkg;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_PAUSE = 2'd1;
  localparam logic [1:0] OP_KILL  = 2'd2;

  localparam logic [1:0] EV_BREAK  = 2'd0;
  localparam logic [1:0] EV_FIRST  = 2'd1;
  localparam logic [1:0] EV_LONG   = 2'd2;
  localparam logic [1:0] EV_REPEAT = 2'd3;

  localparam logic [3:0] ST_OFF    = 4'd0;
  localparam logic [3:0] ST_START  = 4'd1;
  localparam logic [3:0] ST_DELAY  = 4'd2;
  localparam logic [3:0] ST_PAUSE  = 4'd3;
  localparam logic [3:0] ST_KILLED = 4'd4;
  localparam logic [3:0] ST_REP0   = 4'd5;
  localparam logic [3:0] ST_REP3   = 4'd8;
  localparam logic [3:0] ST_REP4   = 4'd9;

  localparam logic [2:0] REG_LONG   = 3'd0;
  localparam logic [2:0] REG_RSTART = 3'd1;
  localparam logic [2:0] REG_RSTEP  = 3'd2;
  localparam logic [2:0] REG_PAUSE  = 3'd3;
  localparam logic [2:0] REG_DEB    = 3'd4;
  localparam logic [2:0] REG_SHIFT  = 3'd5;

  localparam logic [7:0]  RST_LONG   = 8'd32;
  localparam logic [7:0]  RST_RSTART = 8'd40;
  localparam logic [7:0]  RST_RSTEP  = 8'd48;
  localparam logic [7:0]  RST_PAUSE  = 8'd64;
  localparam logic [3:0]  RST_DEB    = 4'd4;
  localparam logic [15:0] RST_SHIFT  = 16'd0;

  typedef struct packed {
    logic [7:0]  long_press_ticks;
    logic [7:0]  repeat_start_ticks;
    logic [7:0]  repeat_step_ticks;
    logic [7:0]  pause_ticks;
    logic [3:0]  debounce_bits;
    logic [15:0] shift_key_mask;
  } cfg_t;

  typedef struct packed {
    logic [7:0] hist;
    logic [3:0] st;
    logic [7:0] cnt;
  } key_rec_t;

endpackage

// File: hdl/kdeg_if.sv
// Handshake channel interfaces: input items, result items, register writes
`timescale 1ns / 1ps
interface kdeg_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [3:0] key_index;
  logic       level;
  modport source (output valid, output operation, output key_index, output level, input ready);
  modport sink (input valid, input operation, input key_index, input level, output ready);
endinterface

interface kdeg_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] event_key;
  logic [1:0] event_kind;
  modport source (output valid, output event_key, output event_kind, input ready);
  modport sink (input valid, input event_key, input event_kind, output ready);
endinterface

interface kdeg_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: hdl/kdeg_cfg_regs.sv
// Configuration register file
`timescale 1ns / 1ps
module kdeg_cfg_regs (
  input  logic            clk,
  input  logic            rst_n,
  kdeg_cfg_if.sink        cfg_ch,
  output kdeg_pkg::cfg_t  cfg
);

  kdeg_pkg::cfg_t cfg_r;

  assign cfg_ch.ready = 1'b1;
  assign cfg          = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.long_press_ticks   <= kdeg_pkg::RST_LONG;
      cfg_r.repeat_start_ticks <= kdeg_pkg::RST_RSTART;
      cfg_r.repeat_step_ticks  <= kdeg_pkg::RST_RSTEP;
      cfg_r.pause_ticks        <= kdeg_pkg::RST_PAUSE;
      cfg_r.debounce_bits      <= kdeg_pkg::RST_DEB;
      cfg_r.shift_key_mask     <= kdeg_pkg::RST_SHIFT;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        kdeg_pkg::REG_LONG:   cfg_r.long_press_ticks   <= cfg_ch.data[7:0];
        kdeg_pkg::REG_RSTART: cfg_r.repeat_start_ticks <= cfg_ch.data[7:0];
        kdeg_pkg::REG_RSTEP:  cfg_r.repeat_step_ticks  <= cfg_ch.data[7:0];
        kdeg_pkg::REG_PAUSE:  cfg_r.pause_ticks        <= cfg_ch.data[7:0];
        kdeg_pkg::REG_DEB:    cfg_r.debounce_bits      <= cfg_ch.data[3:0];
        kdeg_pkg::REG_SHIFT:  cfg_r.shift_key_mask     <= cfg_ch.data;
        default: ;
      endcase
    end
  end

endmodule

// File: hdl/kdeg_step.sv
// Next key record and event for one item
`timescale 1ns / 1ps
module kdeg_step (
  input  kdeg_pkg::cfg_t      cfg,
  input  kdeg_pkg::key_rec_t  cur,
  input  logic [1:0]          operation,
  input  logic                level,
  input  logic                shift_key,
  output kdeg_pkg::key_rec_t  nxt,
  output logic                emit,
  output logic [1:0]          kind
);

  logic [3:0] nb;
  logic [7:0] mask;
  logic [7:0] hist;
  logic [7:0] cnt;
  logic [2:0] lvl;
  logic       lvl_step;
  logic [2:0] lvl_n;
  logic [7:0] rep_cnt;
  logic [4:0] imask;
  logic       rep_hit;

  assign nb = (cfg.debounce_bits == 4'd0) ? 4'd1 :
              (cfg.debounce_bits > 4'd8) ? 4'd8 : cfg.debounce_bits;
  assign mask = 8'hFF >> (4'd8 - nb);
  assign hist = {cur.hist[6:0], level};
  assign cnt  = cur.cnt + 8'd1;

  assign lvl      = 3'(cur.st - kdeg_pkg::ST_REP0);
  assign lvl_step = (lvl != 3'd0) && (cnt >= cfg.repeat_step_ticks);
  assign lvl_n    = lvl_step ? lvl - 3'd1 : lvl;
  assign rep_cnt  = lvl_step ? 8'd0 : cnt;
  assign imask    = 5'((5'd1 << lvl_n) - 5'd1);
  assign rep_hit  = ((rep_cnt[4:0] & imask) == 5'd0) && !shift_key;

  always_comb begin
    nxt  = cur;
    emit = 1'b0;
    kind = kdeg_pkg::EV_BREAK;
    unique case (operation)
      kdeg_pkg::OP_TICK: begin
        nxt.hist = hist;
        nxt.cnt  = cnt;
        if (cur.st != kdeg_pkg::ST_OFF && hist == 8'd0) begin
          nxt.st  = kdeg_pkg::ST_OFF;
          nxt.cnt = 8'd0;
          emit    = (cur.st != kdeg_pkg::ST_KILLED);
        end else begin
          unique case (cur.st) inside
            kdeg_pkg::ST_OFF: begin
              if (hist == mask) begin
                nxt.st  = kdeg_pkg::ST_START;
                nxt.cnt = 8'd0;
              end
            end
            kdeg_pkg::ST_START: begin
              nxt.st  = kdeg_pkg::ST_DELAY;
              nxt.cnt = 8'd0;
              emit    = 1'b1;
              kind    = kdeg_pkg::EV_FIRST;
            end
            kdeg_pkg::ST_DELAY: begin
              if (cnt == cfg.long_press_ticks) begin
                emit = 1'b1;
                kind = kdeg_pkg::EV_LONG;
              end
              if (cnt == cfg.repeat_start_ticks) begin
                nxt.st  = kdeg_pkg::ST_REP4;
                nxt.cnt = 8'd0;
              end
            end
            kdeg_pkg::ST_PAUSE: begin
              if (cnt >= cfg.pause_ticks) begin
                nxt.st  = kdeg_pkg::ST_REP3;
                nxt.cnt = 8'd0;
              end
            end
            [kdeg_pkg::ST_REP0:kdeg_pkg::ST_REP4]: begin
              nxt.st  = kdeg_pkg::ST_REP0 + 4'(lvl_n);
              nxt.cnt = rep_cnt;
              emit    = rep_hit;
              kind    = kdeg_pkg::EV_REPEAT;
            end
            default: ;
          endcase
        end
      end
      kdeg_pkg::OP_PAUSE: begin
        nxt.st  = kdeg_pkg::ST_PAUSE;
        nxt.cnt = 8'd0;
      end
      kdeg_pkg::OP_KILL: begin
        nxt.st = kdeg_pkg::ST_KILLED;
      end
      default: ;
    endcase
  end

endmodule

// File: hdl/key_debounce_event_generator.sv
// Key debounce event generator: top level with item, key and result registers
//
// Channels: in_ch takes items (operation, key_index, level); out_ch delivers
// events (event_key, event_kind); cfg_ch writes registers by index, always ready.
// A tick item shifts the key level into that key's history and may raise one
// event: FIRST after debounce, LONG, accelerating REPEAT, or BREAK on release.
// Pause and kill items only change the key's state and give no event.
// An accepted item waits in the input register; its event is then written
// to the result register. Throughput: one item per cycle unless out_ch stalls,
// set by the single read-modify-write of the per-key record in the flop array.
// Per-key records and registers are cleared by the synchronous reset; no
// clearing pass follows it, so in_ch is ready from the first cycle after it.
// When out_ch stalls, the result register holds its event; one more item
// waits in the input register, after which in_ch ready drops until the
// event is taken.
`timescale 1ns / 1ps
`include "key_debounce_event_generator_macros.svh"
module key_debounce_event_generator #(
  parameter int KEY_COUNT = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  kdeg_in_if.sink    in_ch,
  kdeg_out_if.source out_ch,
  kdeg_cfg_if.sink   cfg_ch
);

  localparam int KEY_IW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
  localparam logic [5:0] KEY_LIM = 6'(KEY_COUNT);

  kdeg_pkg::cfg_t     cfg;
  kdeg_pkg::key_rec_t keys_r [KEY_COUNT];
  kdeg_pkg::key_rec_t cur;
  kdeg_pkg::key_rec_t nxt;

  logic              in_vld_r;
  logic [1:0]        op_r;
  logic [3:0]        key_r;
  logic              level_r;
  logic              out_valid_r;
  logic [3:0]        out_key_r;
  logic [1:0]        out_kind_r;

  logic              advance;
  logic              proc;
  logic              key_ok;
  logic [KEY_IW-1:0] idx;
  logic              emit;
  logic [1:0]        kind;

  kdeg_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  assign advance     = !out_valid_r || out_ch.ready;
  assign proc        = in_vld_r && advance;
  assign in_ch.ready = !in_vld_r || advance;
  assign key_ok      = {2'b00, key_r} < KEY_LIM;
  assign idx         = KEY_IW'(key_r);
  assign cur         = keys_r[idx];

  kdeg_step u_step (
    .cfg       (cfg),
    .cur       (cur),
    .operation (op_r),
    .level     (level_r),
    .shift_key (cfg.shift_key_mask[key_r]),
    .nxt       (nxt),
    .emit      (emit),
    .kind      (kind)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      op_r    <= in_ch.operation;
      key_r   <= in_ch.key_index;
      level_r <= in_ch.level;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < KEY_COUNT; i++) begin
        keys_r[i] <= '0;
      end
    end else if (proc && key_ok) begin
      keys_r[idx] <= nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= proc && key_ok && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && key_ok && emit) begin
      out_key_r  <= key_r;
      out_kind_r <= kind;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.event_key  = out_key_r;
  assign out_ch.event_kind = out_kind_r;

  `KDEG_ASSERT_NXT(a_hold_item, clk, rst_n, in_vld_r && !advance, in_vld_r, "item dropped while stalled")
  `KDEG_ASSERT_IMP(a_ready_free, clk, rst_n, !in_ch.ready, in_vld_r && out_valid_r, "ready low without backlog")
  `KDEG_ASSERT_NXT(a_bad_key, clk, rst_n, proc && !key_ok, !out_valid_r, "event for absent key")
  `KDEG_ASSERT_NXT(a_killed, clk, rst_n, proc && key_ok && cur.st == kdeg_pkg::ST_KILLED, !out_valid_r, "event from killed key")

endmodule
